[hw/rtl/grid_zone_membership_table_assert.svh]
// Assertion macros shared by the zone membership table RTL.
`ifndef GRID_ZONE_MEMBERSHIP_TABLE_ASSERT_SVH
`define GRID_ZONE_MEMBERSHIP_TABLE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define GZMT_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("zone membership table check failed");

// Consequent must hold in the cycle after the antecedent.
`define GZMT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("zone membership table check failed");

`endif

[hw/rtl/gzmt_pkg.sv]
// Shared constants, types and helpers of the zone membership table.
`timescale 1ns / 1ps

package gzmt_pkg;

    // Grid and table sizing.
    localparam int ZONE_DIVISIONS = 16;
    localparam int LOCAL_WORLDS   = 2;
    localparam int ZONE_CAPACITY  = 32;
    localparam int GRID_SCALE     = 16;
    localparam int CELLS_PER_ZONE = 64;
    localparam int ENTITY_ID_BITS = 16;

    localparam int NUM_TYPES   = 4;
    localparam int NUM_ZONES   = ZONE_DIVISIONS * ZONE_DIVISIONS;
    localparam int NUM_LISTS   = LOCAL_WORLDS * NUM_TYPES * NUM_ZONES;
    localparam int ZONE_BITS   = $clog2(NUM_ZONES);
    localparam int LIST_BITS   = $clog2(NUM_LISTS);
    localparam int IDX_BITS    = (ZONE_CAPACITY > 1) ? $clog2(ZONE_CAPACITY) : 1;
    localparam int CNT_W       = $clog2(ZONE_CAPACITY + 1);
    localparam int STORE_BITS  = LIST_BITS + IDX_BITS;
    localparam int STORE_DEPTH = NUM_LISTS << IDX_BITS;

    // Both scale factors are powers of two, so the zone is a plain shift.
    localparam int ZONE_SHIFT = $clog2(GRID_SCALE * CELLS_PER_ZONE);

    // Field widths of the words on the ports.
    localparam int KIND_W     = 2;
    localparam int TYPE_W     = 2;
    localparam int ID_IN_W    = 16;
    localparam int SLOT_W     = 2;
    localparam int GIVEN_W    = 9;
    localparam int POS_W      = 24;
    localparam int ZONE_OUT_W = 8;
    localparam int STATUS_W   = 3;
    localparam int LIMIT_W    = 6;

    localparam int IN_DATA_W  = 80;
    localparam int OUT_DATA_W = 16;
    localparam int PADDR_W    = 4;
    localparam int PDATA_W    = 32;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(32);

    typedef enum logic [KIND_W-1:0] {
        KIND_MOVE   = 2'd0,
        KIND_ADD    = 2'd1,
        KIND_REMOVE = 2'd2,
        KIND_NONE   = 2'd3
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE       = 3'd0,
        ST_UNCHANGED  = 3'd1,
        ST_OUTSIDE    = 3'd2,
        ST_FULL       = 3'd3,
        ST_NOT_FOUND  = 3'd4,
        ST_NOT_SERVED = 3'd5
    } status_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DECIDE,
        S_RM_CNT,
        S_RM_FIRST,
        S_RM_SRCH,
        S_RM_SWAP,
        S_AD_CNT,
        S_AD_WR,
        S_FINISH
    } state_t;

    typedef struct packed {
        kind_t                     kind;
        logic [TYPE_W-1:0]         entity_type;
        logic [ID_IN_W-1:0]        entity_id;
        logic [SLOT_W-1:0]         world_slot;
        logic signed [GIVEN_W-1:0] zone_given;
        logic signed [POS_W-1:0]   pos_x;
        logic signed [POS_W-1:0]   pos_y;
    } item_t;

    typedef struct packed {
        logic [ZONE_OUT_W-1:0] zone_index;
        logic                  zone_valid;
        status_t               status;
    } result_t;

    typedef struct packed {
        logic                 ok;
        logic [ZONE_BITS-1:0] zone;
    } zone_t;

    typedef struct packed {
        logic take;
        logic res_free;
    } seq_ctrl_t;

    typedef struct packed {
        logic ready;
        logic clearing;
        logic done;
    } seq_stat_t;

    typedef logic [NUM_TYPES-1:0][LIMIT_W-1:0] limits_t;

    // Flat list number of a (world slot, entity type, zone) triple.
    function automatic logic [LIST_BITS-1:0] list_of(
        input logic [SLOT_W-1:0]    slot,
        input logic [TYPE_W-1:0]    etype,
        input logic [ZONE_BITS-1:0] zone
    );
        int unsigned idx;
        idx = (int'(slot) * NUM_TYPES + int'(etype)) * NUM_ZONES + int'(zone);
        return idx[LIST_BITS-1:0];
    endfunction

endpackage

[hw/rtl/grid_zone_membership_table.sv]
// Top level of the grid zone membership table: ports, limit registers, result register.
`timescale 1ns / 1ps
`include "grid_zone_membership_table_assert.svh"

// For each local world slot, grid zone and entity type (pc, monster, npc,
// object) this block keeps a bounded list of entity ids together with a
// count. One input word carries one command: a move by position, an add to a
// given zone or a remove from a given zone, and every command returns exactly
// one result word with the zone concerned and a status code. The counts live
// in a 2048-entry memory and the ids in a 65536-entry memory, both with one
// write and one registered read port; commands are handled one at a time by a
// read-modify-write sequencer, so accesses never overlap. After reset the
// block sweeps the count memory to zero, one list per cycle, and holds
// s_axis_tready low until the sweep is done; limit registers may be written
// meanwhile. The result word appears in the same cycle as the block becomes
// ready for the next word. A remove compares the stored ids one by one, and
// a move that changes zones pays its remove and then its add. The search
// dominates: the id memory delivers one entry per cycle. The next word is
// taken as soon as the sequencer is idle, even while the last result still
// waits in the output register.
module grid_zone_membership_table (
    input  logic                             clk,
    input  logic                             rst_n,

    // Limit registers: limit_pc at 0x0, limit_monster at 0x4, limit_npc at
    // 0x8, limit_object at 0xC.
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [gzmt_pkg::PADDR_W-1:0]     paddr,
    input  logic [gzmt_pkg::PDATA_W-1:0]     pwdata,
    output logic [gzmt_pkg::PDATA_W-1:0]     prdata,
    output logic                             pready,

    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // entity_type[1:0], entity_id[17:2], world_slot[19:18], zone_given[28:20],
    // pos_x[52:29], pos_y[76:53], zero[79:77]
    input  logic [gzmt_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // kind[1:0]
    input  logic [gzmt_pkg::KIND_W-1:0]      s_axis_tuser,

    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // zone_index[7:0], zone_valid[8], status[11:9], zero[15:12]
    output logic [gzmt_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);

    localparam int REG_IDX_W = $clog2(gzmt_pkg::NUM_TYPES);

    gzmt_pkg::limits_t   limit_reg, limit_next;
    logic                m_tvalid_reg, m_tvalid_next;
    logic [gzmt_pkg::OUT_DATA_W-1:0] m_tdata_reg, m_tdata_next;

    gzmt_pkg::item_t     item_in;
    gzmt_pkg::seq_ctrl_t seq_ctrl;
    gzmt_pkg::seq_stat_t seq_stat;
    gzmt_pkg::result_t   seq_res;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                cfg_write;

    // Register file. The word index is taken from the address above the byte
    // offset; every index names one of the four limits.
    assign reg_idx   = paddr[REG_IDX_W+1:2];
    assign cfg_write = psel && penable && pwrite;
    assign pready    = 1'b1;
    assign prdata    = gzmt_pkg::PDATA_W'(limit_reg[reg_idx]);

    always_comb
    begin
        limit_next = limit_reg;
        if (cfg_write)
        begin
            limit_next[reg_idx] = pwdata[gzmt_pkg::LIMIT_W-1:0];
        end
    end

    // Unpack the input word.
    always_comb
    begin
        item_in.kind        = gzmt_pkg::kind_t'(s_axis_tuser);
        item_in.entity_type = s_axis_tdata[1:0];
        item_in.entity_id   = s_axis_tdata[17:2];
        item_in.world_slot  = s_axis_tdata[19:18];
        item_in.zone_given  = s_axis_tdata[28:20];
        item_in.pos_x       = s_axis_tdata[52:29];
        item_in.pos_y       = s_axis_tdata[76:53];
    end

    assign s_axis_tready     = seq_stat.ready;
    assign seq_ctrl.take     = s_axis_tvalid && seq_stat.ready;
    assign seq_ctrl.res_free = !m_tvalid_reg || m_axis_tready;

    gzmt_seq u_seq (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (seq_ctrl),
        .item_in (item_in),
        .limits  (limit_reg),
        .stat    (seq_stat),
        .res     (seq_res)
    );

    // Output register: the sequencer hands over a result only when this
    // register is empty or being emptied in the same cycle.
    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        if (seq_stat.done)
        begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = gzmt_pkg::OUT_DATA_W'({seq_res.status, seq_res.zone_valid,
                                                   seq_res.zone_index});
        end
        else if (m_axis_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg    <= {gzmt_pkg::NUM_TYPES{gzmt_pkg::LIMIT_RESET}};
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            limit_reg    <= limit_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_tdata_reg <= m_tdata_next;
    end

    assign m_axis_tvalid = m_tvalid_reg;
    assign m_axis_tdata  = m_tdata_reg;

    // No word may be taken while the count memory is still being cleared.
    `GZMT_ASSERT_SAME(a_no_take_clearing, clk, rst_n, seq_stat.clearing, !s_axis_tready)
    // A taken word keeps the sequencer busy in the following cycle.
    `GZMT_ASSERT_NEXT(a_one_word, clk, rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)
    // A finished result never overwrites one that is still waiting.
    `GZMT_ASSERT_SAME(a_result_room, clk, rst_n, seq_stat.done, !m_tvalid_reg || m_axis_tready)
    // A result outside the grid carries zone zero.
    `GZMT_ASSERT_SAME(a_zone_zero, clk, rst_n, seq_stat.done && !seq_res.zone_valid, seq_res.zone_index == '0)

endmodule

[hw/rtl/gzmt_ram.sv]
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps

module gzmt_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[hw/rtl/gzmt_zone.sv]
// Registered conversion of an integer position into a grid zone.
`timescale 1ns / 1ps

module gzmt_zone (
    input  logic                              clk,
    input  logic                              en,
    input  logic signed [gzmt_pkg::POS_W-1:0] pos_x,
    input  logic signed [gzmt_pkg::POS_W-1:0] pos_y,
    output gzmt_pkg::zone_t                   zone
);

    localparam int MAG_W = gzmt_pkg::POS_W + 1;

    gzmt_pkg::zone_t zone_reg;
    gzmt_pkg::zone_t zone_next;

    logic             ok_x;
    logic             ok_y;
    logic [MAG_W-1:0] q_x;
    logic [MAG_W-1:0] q_y;

    // Truncating division toward zero: divide the magnitude, and a negative
    // coordinate lands inside the grid only when its quotient is zero.
    function automatic logic [MAG_W:0] axis_zone(input logic signed [gzmt_pkg::POS_W-1:0] p);
        logic signed [MAG_W-1:0] wide;
        logic [MAG_W-1:0]        mag;
        logic [MAG_W-1:0]        q;
        logic                    ok;
        wide = MAG_W'(p);
        mag  = p[gzmt_pkg::POS_W-1] ? MAG_W'(-wide) : MAG_W'(wide);
        q    = mag >> gzmt_pkg::ZONE_SHIFT;
        if (p[gzmt_pkg::POS_W-1])
        begin
            ok = (q == '0);
        end
        else
        begin
            ok = (32'(q) < gzmt_pkg::ZONE_DIVISIONS);
        end
        return {ok, q};
    endfunction

    always_comb
    begin
        {ok_x, q_x} = axis_zone(pos_x);
        {ok_y, q_y} = axis_zone(pos_y);
        zone_next.ok   = ok_x && ok_y;
        zone_next.zone = gzmt_pkg::ZONE_BITS'(
            32'(q_x[gzmt_pkg::ZONE_BITS-1:0]) * gzmt_pkg::ZONE_DIVISIONS
            + 32'(q_y[gzmt_pkg::ZONE_BITS-1:0]));
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            zone_reg <= zone_next;
        end
    end

    assign zone = zone_reg;

endmodule

[hw/rtl/gzmt_seq.sv]
// Sequencer that reads, modifies and writes back the count and id memories.
`timescale 1ns / 1ps

module gzmt_seq (
    input  logic                clk,
    input  logic                rst_n,
    input  gzmt_pkg::seq_ctrl_t ctrl,
    input  gzmt_pkg::item_t     item_in,
    input  gzmt_pkg::limits_t   limits,
    output gzmt_pkg::seq_stat_t stat,
    output gzmt_pkg::result_t   res
);

    localparam int LB = gzmt_pkg::LIST_BITS;
    localparam int IB = gzmt_pkg::IDX_BITS;
    localparam int CW = gzmt_pkg::CNT_W;
    localparam int SB = gzmt_pkg::STORE_BITS;
    localparam int EB = gzmt_pkg::ENTITY_ID_BITS;

    gzmt_pkg::state_t  state_reg, state_next;
    gzmt_pkg::item_t   item_reg, item_next;
    gzmt_pkg::result_t res_reg, res_next;
    logic [LB-1:0]     clr_cnt_reg, clr_cnt_next;
    logic [LB-1:0]     list_reg, list_next;
    logic [LB-1:0]     add_list_reg, add_list_next;
    logic              add_after_reg, add_after_next;
    logic [CW-1:0]     n_reg, n_next;
    logic [CW-1:0]     rd_idx_reg, rd_idx_next;
    logic [IB-1:0]     hole_reg, hole_next;

    gzmt_pkg::zone_t   cur;

    logic              cnt_we, cnt_re;
    logic [LB-1:0]     cnt_waddr, cnt_raddr;
    logic [CW-1:0]     cnt_wdata, cnt_rdata;
    logic              st_we, st_re;
    logic [SB-1:0]     st_waddr, st_raddr;
    logic [EB-1:0]     st_wdata, st_rdata;

    logic                          slot_ok;
    logic                          given_ok;
    logic [gzmt_pkg::ZONE_BITS-1:0] given_zone;
    logic                          unchanged;
    logic [CW-1:0]                 cnt_n;
    logic [EB-1:0]                 id_w;
    logic                          hit;
    logic                          search_end;
    logic                          ad_full;
    logic                          rm_done;
    logic                          rm_found;
    logic [CW-1:0]                 cmp_idx;
    logic [CW-1:0]                 last_idx;

    gzmt_ram #(
        .WIDTH (CW),
        .DEPTH (gzmt_pkg::NUM_LISTS)
    ) u_count_ram (
        .clk   (clk),
        .we    (cnt_we),
        .waddr (cnt_waddr),
        .wdata (cnt_wdata),
        .re    (cnt_re),
        .raddr (cnt_raddr),
        .rdata (cnt_rdata)
    );

    gzmt_ram #(
        .WIDTH (EB),
        .DEPTH (gzmt_pkg::STORE_DEPTH)
    ) u_id_ram (
        .clk   (clk),
        .we    (st_we),
        .waddr (st_waddr),
        .wdata (st_wdata),
        .re    (st_re),
        .raddr (st_raddr),
        .rdata (st_rdata)
    );

    gzmt_zone u_zone (
        .clk   (clk),
        .en    (ctrl.take && (state_reg == gzmt_pkg::S_IDLE)),
        .pos_x (item_in.pos_x),
        .pos_y (item_in.pos_y),
        .zone  (cur)
    );

    // Decode of the held word and of the memory read data.
    always_comb
    begin
        slot_ok    = (32'(item_reg.world_slot) < gzmt_pkg::LOCAL_WORLDS);
        given_ok   = !item_reg.zone_given[gzmt_pkg::GIVEN_W-1]
                     && (32'(item_reg.zone_given[gzmt_pkg::GIVEN_W-2:0]) < gzmt_pkg::NUM_ZONES);
        given_zone = gzmt_pkg::ZONE_BITS'(item_reg.zone_given[gzmt_pkg::GIVEN_W-2:0]);
        unchanged  = (cur.ok && given_ok && (cur.zone == given_zone)) || (!cur.ok && !given_ok);
        cnt_n      = (32'(cnt_rdata) > gzmt_pkg::ZONE_CAPACITY)
                     ? CW'(gzmt_pkg::ZONE_CAPACITY) : cnt_rdata;
        id_w       = EB'(item_reg.entity_id);
        hit        = (st_rdata == id_w);
        search_end = (rd_idx_reg == n_reg);
        cmp_idx    = rd_idx_reg - CW'(1);
        last_idx   = n_reg - CW'(1);
        ad_full    = (32'(cnt_rdata) >= 32'(limits[item_reg.entity_type]))
                     || (32'(cnt_rdata) >= gzmt_pkg::ZONE_CAPACITY);
        rm_done    = ((state_reg == gzmt_pkg::S_RM_FIRST) && (cnt_n == '0))
                     || ((state_reg == gzmt_pkg::S_RM_SRCH) && !hit && search_end)
                     || (state_reg == gzmt_pkg::S_RM_SWAP);
        rm_found   = (state_reg == gzmt_pkg::S_RM_SWAP);
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            gzmt_pkg::S_CLEAR:
            begin
                if (clr_cnt_reg == LB'(gzmt_pkg::NUM_LISTS - 1))
                begin
                    state_next = gzmt_pkg::S_IDLE;
                end
            end
            gzmt_pkg::S_IDLE:
            begin
                if (ctrl.take)
                begin
                    state_next = gzmt_pkg::S_DECIDE;
                end
            end
            gzmt_pkg::S_DECIDE:
            begin
                state_next = gzmt_pkg::S_FINISH;
                if (slot_ok)
                begin
                    unique case (item_reg.kind)
                        gzmt_pkg::KIND_MOVE:
                        begin
                            if (!unchanged)
                            begin
                                state_next = given_ok ? gzmt_pkg::S_RM_CNT
                                                      : gzmt_pkg::S_AD_CNT;
                            end
                        end
                        gzmt_pkg::KIND_ADD:
                        begin
                            if (given_ok)
                            begin
                                state_next = gzmt_pkg::S_AD_CNT;
                            end
                        end
                        gzmt_pkg::KIND_REMOVE:
                        begin
                            if (given_ok)
                            begin
                                state_next = gzmt_pkg::S_RM_CNT;
                            end
                        end
                        gzmt_pkg::KIND_NONE:
                        begin
                            state_next = gzmt_pkg::S_FINISH;
                        end
                    endcase
                end
            end
            gzmt_pkg::S_RM_CNT:
            begin
                state_next = gzmt_pkg::S_RM_FIRST;
            end
            gzmt_pkg::S_RM_FIRST,
            gzmt_pkg::S_RM_SRCH,
            gzmt_pkg::S_RM_SWAP:
            begin
                if (rm_done)
                begin
                    state_next = add_after_reg ? gzmt_pkg::S_AD_CNT : gzmt_pkg::S_FINISH;
                end
                else if (state_reg == gzmt_pkg::S_RM_FIRST)
                begin
                    state_next = gzmt_pkg::S_RM_SRCH;
                end
                else if (hit)
                begin
                    state_next = gzmt_pkg::S_RM_SWAP;
                end
            end
            gzmt_pkg::S_AD_CNT:
            begin
                state_next = gzmt_pkg::S_AD_WR;
            end
            gzmt_pkg::S_AD_WR:
            begin
                state_next = gzmt_pkg::S_FINISH;
            end
            gzmt_pkg::S_FINISH:
            begin
                if (ctrl.res_free)
                begin
                    state_next = gzmt_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = gzmt_pkg::S_IDLE;
            end
        endcase
    end

    // Memory port controls and status toward the top level.
    always_comb
    begin
        cnt_we    = 1'b0;
        cnt_waddr = list_reg;
        cnt_wdata = '0;
        cnt_re    = 1'b0;
        cnt_raddr = list_reg;
        st_we     = 1'b0;
        st_waddr  = {list_reg, hole_reg};
        st_wdata  = st_rdata;
        st_re     = 1'b0;
        st_raddr  = {list_reg, rd_idx_reg[IB-1:0]};

        stat.ready    = (state_reg == gzmt_pkg::S_IDLE);
        stat.clearing = (state_reg == gzmt_pkg::S_CLEAR);
        stat.done     = (state_reg == gzmt_pkg::S_FINISH) && ctrl.res_free;

        unique case (state_reg)
            gzmt_pkg::S_CLEAR:
            begin
                cnt_we    = 1'b1;
                cnt_waddr = clr_cnt_reg;
            end
            gzmt_pkg::S_RM_CNT,
            gzmt_pkg::S_AD_CNT:
            begin
                cnt_re = 1'b1;
            end
            gzmt_pkg::S_RM_FIRST:
            begin
                st_re    = (cnt_n != '0);
                st_raddr = {list_reg, IB'(0)};
            end
            gzmt_pkg::S_RM_SRCH:
            begin
                if (hit)
                begin
                    st_re    = 1'b1;
                    st_raddr = {list_reg, last_idx[IB-1:0]};
                end
                else if (!search_end)
                begin
                    st_re = 1'b1;
                end
            end
            gzmt_pkg::S_RM_SWAP:
            begin
                st_we     = 1'b1;
                cnt_we    = 1'b1;
                cnt_wdata = last_idx;
            end
            gzmt_pkg::S_AD_WR:
            begin
                st_we     = !ad_full;
                st_waddr  = {list_reg, cnt_rdata[IB-1:0]};
                st_wdata  = id_w;
                cnt_we    = !ad_full;
                cnt_wdata = cnt_rdata + CW'(1);
            end
            default:
            begin
                cnt_we = 1'b0;
            end
        endcase
    end

    // Working registers and the result.
    always_comb
    begin
        item_next      = item_reg;
        res_next       = res_reg;
        clr_cnt_next   = clr_cnt_reg;
        list_next      = list_reg;
        add_list_next  = add_list_reg;
        add_after_next = add_after_reg;
        n_next         = n_reg;
        rd_idx_next    = rd_idx_reg;
        hole_next      = hole_reg;

        case (state_reg)
            gzmt_pkg::S_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + LB'(1);
            end
            gzmt_pkg::S_IDLE:
            begin
                if (ctrl.take)
                begin
                    item_next = item_in;
                end
            end
            gzmt_pkg::S_DECIDE:
            begin
                add_after_next      = 1'b0;
                res_next.zone_index = '0;
                res_next.zone_valid = 1'b0;
                res_next.status     = gzmt_pkg::ST_UNCHANGED;
                if (!slot_ok)
                begin
                    res_next.status = gzmt_pkg::ST_NOT_SERVED;
                end
                else if (item_reg.kind == gzmt_pkg::KIND_MOVE)
                begin
                    if (unchanged)
                    begin
                        res_next.zone_index = cur.ok ? gzmt_pkg::ZONE_OUT_W'(cur.zone) : '0;
                        res_next.zone_valid = cur.ok;
                    end
                    else
                    begin
                        list_next = given_ok
                            ? gzmt_pkg::list_of(item_reg.world_slot, item_reg.entity_type,
                                                given_zone)
                            : gzmt_pkg::list_of(item_reg.world_slot, item_reg.entity_type,
                                                cur.zone);
                        add_list_next  = gzmt_pkg::list_of(item_reg.world_slot,
                                                           item_reg.entity_type, cur.zone);
                        add_after_next = given_ok && cur.ok;
                        if (cur.ok)
                        begin
                            res_next.zone_index = gzmt_pkg::ZONE_OUT_W'(cur.zone);
                            res_next.zone_valid = 1'b1;
                            res_next.status     = gzmt_pkg::ST_DONE;
                        end
                        else
                        begin
                            res_next.status = gzmt_pkg::ST_OUTSIDE;
                        end
                    end
                end
                else if ((item_reg.kind == gzmt_pkg::KIND_ADD)
                         || (item_reg.kind == gzmt_pkg::KIND_REMOVE))
                begin
                    if (given_ok)
                    begin
                        list_next = gzmt_pkg::list_of(item_reg.world_slot,
                                                      item_reg.entity_type, given_zone);
                        res_next.zone_index = gzmt_pkg::ZONE_OUT_W'(given_zone);
                        res_next.zone_valid = 1'b1;
                        res_next.status     = gzmt_pkg::ST_DONE;
                    end
                    else
                    begin
                        res_next.status = gzmt_pkg::ST_OUTSIDE;
                    end
                end
            end
            gzmt_pkg::S_RM_FIRST:
            begin
                n_next      = cnt_n;
                rd_idx_next = CW'(1);
            end
            gzmt_pkg::S_RM_SRCH:
            begin
                if (hit)
                begin
                    hole_next = cmp_idx[IB-1:0];
                end
                else if (!search_end)
                begin
                    rd_idx_next = rd_idx_reg + CW'(1);
                end
            end
            gzmt_pkg::S_AD_WR:
            begin
                res_next.status = ad_full ? gzmt_pkg::ST_FULL : gzmt_pkg::ST_DONE;
            end
            default:
            begin
                hole_next = hole_reg;
            end
        endcase

        // End of a removal: either go on to the add of a move, or report.
        if (rm_done)
        begin
            if (add_after_reg)
            begin
                list_next = add_list_reg;
            end
            if (item_reg.kind == gzmt_pkg::KIND_REMOVE)
            begin
                res_next.status = rm_found ? gzmt_pkg::ST_DONE : gzmt_pkg::ST_NOT_FOUND;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= gzmt_pkg::S_CLEAR;
            clr_cnt_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg      <= item_next;
        res_reg       <= res_next;
        list_reg      <= list_next;
        add_list_reg  <= add_list_next;
        add_after_reg <= add_after_next;
        n_reg         <= n_next;
        rd_idx_reg    <= rd_idx_next;
        hole_reg      <= hole_next;
    end

    assign res = res_reg;

endmodule

[verif/tb.sv]
// Self-checking testbench for the grid zone membership table.
`timescale 1ns / 1ps

import gzmt_pkg::*;

// Tracks every zone list the block keeps and works out the result word that
// each accepted command must produce. Expected words wait in order, since the
// block handles one command at a time.
class zone_list_tracker;
    logic [ID_IN_W-1:0] member_ids [NUM_LISTS][ZONE_CAPACITY];
    int unsigned        member_total [NUM_LISTS];
    logic [LIMIT_W-1:0] type_limit [NUM_TYPES];
    result_t            pending_results [$];
    int                 mismatches;

    function new();
        foreach (type_limit[t])
            type_limit[t] = LIMIT_RESET;
        foreach (member_total[l])
            member_total[l] = 0;
        mismatches = 0;
    endfunction

    function void set_limit(int idx, int value);
        type_limit[idx] = LIMIT_W'(value);
    endfunction

    function int list_number(int slot, int etype, int zone);
        return (slot * NUM_TYPES + etype) * NUM_ZONES + zone;
    endfunction

    // Appends an id unless the list has reached the limit of its type or the zone capacity.
    function bit try_add(int lst, int etype, logic [ID_IN_W-1:0] id);
        int unsigned n;
        int unsigned cap;
        n = member_total[lst];
        cap = (type_limit[etype] < ZONE_CAPACITY) ? int'(type_limit[etype]) : ZONE_CAPACITY;
        if (n >= cap)
            return 1'b0;
        member_ids[lst][n] = id;
        member_total[lst] = n + 1;
        return 1'b1;
    endfunction

    // Finds the first copy of an id and fills the hole with the last entry.
    function bit try_remove(int lst, logic [ID_IN_W-1:0] id);
        int unsigned n;
        n = member_total[lst];
        for (int unsigned i = 0; i < n; i++) begin
            if (member_ids[lst][i] == id) begin
                member_ids[lst][i] = member_ids[lst][n-1];
                member_total[lst] = n - 1;
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function void note_command(item_t c);
        result_t r;
        int      given;
        int      px;
        int      py;
        int      zx;
        int      zy;
        int      cur;
        int      slot;
        int      etype;
        bit      given_ok;
        bit      cur_ok;
        given = $signed(c.zone_given);
        px = $signed(c.pos_x);
        py = $signed(c.pos_y);
        slot = int'(c.world_slot);
        etype = int'(c.entity_type);
        // Both divisions truncate toward zero, so small negative coordinates
        // land in row or column 0.
        zx = (px / GRID_SCALE) / CELLS_PER_ZONE;
        zy = (py / GRID_SCALE) / CELLS_PER_ZONE;
        cur_ok = zx >= 0 && zy >= 0 && zx < ZONE_DIVISIONS && zy < ZONE_DIVISIONS;
        cur = zx * ZONE_DIVISIONS + zy;
        given_ok = given >= 0 && given < NUM_ZONES;
        r.zone_index = '0;
        r.zone_valid = 1'b0;
        r.status = ST_UNCHANGED;
        if (slot >= LOCAL_WORLDS) begin
            r.status = ST_NOT_SERVED;
        end
        else if (c.kind == KIND_MOVE) begin
            if ((cur_ok && given_ok && cur == given) || (!cur_ok && !given_ok)) begin
                if (cur_ok) begin
                    r.zone_index = ZONE_OUT_W'(cur);
                    r.zone_valid = 1'b1;
                end
            end
            else begin
                if (given_ok)
                    void'(try_remove(list_number(slot, etype, given), c.entity_id));
                if (!cur_ok) begin
                    r.status = ST_OUTSIDE;
                end
                else begin
                    r.zone_index = ZONE_OUT_W'(cur);
                    r.zone_valid = 1'b1;
                    r.status = try_add(list_number(slot, etype, cur), etype, c.entity_id)
                               ? ST_DONE : ST_FULL;
                end
            end
        end
        else if (c.kind == KIND_ADD || c.kind == KIND_REMOVE) begin
            if (!given_ok) begin
                r.status = ST_OUTSIDE;
            end
            else begin
                r.zone_index = ZONE_OUT_W'(given);
                r.zone_valid = 1'b1;
                if (c.kind == KIND_ADD)
                    r.status = try_add(list_number(slot, etype, given), etype, c.entity_id)
                               ? ST_DONE : ST_FULL;
                else
                    r.status = try_remove(list_number(slot, etype, given), c.entity_id)
                               ? ST_DONE : ST_NOT_FOUND;
            end
        end
        pending_results.push_back(r);
    endfunction

    function void check_result(logic [OUT_DATA_W-1:0] word);
        result_t                 want;
        logic [ZONE_OUT_W-1:0]   got_zone;
        logic                    got_valid;
        logic [STATUS_W-1:0]     got_status;
        got_zone = word[7:0];
        got_valid = word[8];
        got_status = word[11:9];
        if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("result word %h arrived with nothing pending", word);
            return;
        end
        want = pending_results.pop_front();
        if (got_zone !== want.zone_index || got_valid !== want.zone_valid ||
            got_status !== STATUS_W'(want.status)) begin
            mismatches++;
            if (mismatches <= 10)
                $display("result mismatch: expected zone %0d valid %0b status %0d, got zone %0d valid %0b status %0d",
                         want.zone_index, want.zone_valid, want.status,
                         got_zone, got_valid, got_status);
        end
    endfunction
endclass

module tb;

    localparam int CYCLE_LIMIT   = 500000;
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 64;

    localparam int TYPE_PC      = 0;
    localparam int TYPE_MONSTER = 1;
    localparam int TYPE_NPC     = 2;
    localparam int TYPE_OBJECT  = 3;

    typedef enum int {
        REG_LIMIT_PC,
        REG_LIMIT_MONSTER,
        REG_LIMIT_NPC,
        REG_LIMIT_OBJECT
    } limit_reg_e;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   psel = 1'b0;
    logic                   penable = 1'b0;
    logic                   pwrite = 1'b0;
    logic [PADDR_W-1:0]     paddr = '0;
    logic [PDATA_W-1:0]     pwdata = '0;
    logic [PDATA_W-1:0]     prdata;
    logic                   pready;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_DATA_W-1:0]   s_axis_tdata = '0;
    logic [KIND_W-1:0]      s_axis_tuser = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0]  m_axis_tdata;

    zone_list_tracker tracker = new();

    // Random stimulus works on a few lists at a time so that they fill up and
    // removes find what was added.
    bit                 idling = 1'b1;
    bit                 hold_off_request = 1'b0;
    int                 pool_zones [4];
    int                 zone_spread;
    logic [ID_IN_W-1:0] pool_ids [8];
    int                 hot_slot;
    int                 hot_type;
    int                 add_pct;
    int                 remove_pct;
    int unsigned        cycle_count = 0;

    always #6 clk = ~clk;

    grid_zone_membership_table u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    function automatic item_t command(kind_t k, int etype, int id, int slot, int given,
                                      int x, int y);
        item_t c;
        c.kind = k;
        c.entity_type = TYPE_W'(etype);
        c.entity_id = ID_IN_W'(id);
        c.world_slot = SLOT_W'(slot);
        c.zone_given = GIVEN_W'(given);
        c.pos_x = POS_W'(x);
        c.pos_y = POS_W'(y);
        return c;
    endfunction

    // Coordinate inside row or column zc of the grid; row or column 0 also takes
    // small negative values.
    function automatic int coord_in(int zc);
        if (zc == 0 && $urandom_range(0, 2) == 0)
            return -int'($urandom_range(0, 1023));
        return zc * GRID_SCALE * CELLS_PER_ZONE + int'($urandom_range(0, 1023));
    endfunction

    function automatic int coord_outside();
        if ($urandom_range(0, 1) == 0)
            return int'($urandom_range(16384, 8388607));
        return -int'($urandom_range(1024, 8388608));
    endfunction

    function automatic item_t random_command();
        item_t c;
        int    roll;
        int    zone;
        int    etype;
        int    slot;
        roll = $urandom_range(0, 99);
        etype = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 3)) : hot_type;
        slot = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 1)) : hot_slot;
        c = command(KIND_MOVE, etype, int'(pool_ids[$urandom_range(0, 7)]), slot,
                    pool_zones[$urandom_range(0, zone_spread - 1)], 0, 0);
        if ($urandom_range(0, 9) == 0)
            c.entity_id = ID_IN_W'($urandom);
        if (roll < 6) begin
            // Noise: any kind, any slot, raw zone and raw positions.
            c.kind = kind_t'($urandom_range(0, 3));
            c.world_slot = SLOT_W'($urandom_range(0, 3));
            c.zone_given = GIVEN_W'($urandom);
            c.pos_x = POS_W'($urandom);
            c.pos_y = POS_W'($urandom);
        end
        else if (roll < 6 + add_pct) begin
            c.kind = KIND_ADD;
        end
        else if (roll < 6 + add_pct + remove_pct) begin
            c.kind = KIND_REMOVE;
        end
        else begin
            if ($urandom_range(0, 9) == 0)
                c.zone_given = GIVEN_W'(-1);
            if ($urandom_range(0, 11) == 0) begin
                c.pos_x = POS_W'(coord_outside());
                c.pos_y = POS_W'(($urandom_range(0, 1) == 0) ? coord_in(3) : coord_outside());
            end
            else begin
                zone = pool_zones[$urandom_range(0, zone_spread - 1)];
                c.pos_x = POS_W'(coord_in(zone / ZONE_DIVISIONS));
                c.pos_y = POS_W'(coord_in(zone % ZONE_DIVISIONS));
            end
        end
        return c;
    endfunction

    // Register write, setup then access; the tracker follows once it is done.
    task automatic write_limit(input limit_reg_e idx, input int value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= PADDR_W'(int'(idx) * 4);
        pwdata <= PDATA_W'(value);
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        tracker.set_limit(int'(idx), value);
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_limits(input int pc, input int monster, input int npc, input int obj);
        write_limit(REG_LIMIT_PC, pc);
        write_limit(REG_LIMIT_MONSTER, monster);
        write_limit(REG_LIMIT_NPC, npc);
        write_limit(REG_LIMIT_OBJECT, obj);
    endtask

    // Offers one command word and returns at the edge where it is taken.
    task automatic drive_command(input item_t c);
        if (idling && $urandom_range(0, 4) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {3'b000, c.pos_y, c.pos_x, c.zone_given, c.world_slot,
                         c.entity_id, c.entity_type};
        s_axis_tuser <= c.kind;
        do
            @(posedge clk);
        while (!s_axis_tready);
        tracker.note_command(c);
    endtask

    task automatic start_phase(input int spread, input int adds, input int removes);
        zone_spread = spread;
        add_pct = adds;
        remove_pct = removes;
        hot_slot = int'($urandom_range(0, LOCAL_WORLDS - 1));
        hot_type = int'($urandom_range(0, NUM_TYPES - 1));
        foreach (pool_zones[i])
            pool_zones[i] = int'($urandom_range(0, NUM_ZONES - 1));
        foreach (pool_ids[i])
            pool_ids[i] = ID_IN_W'($urandom);
    endtask

    task automatic run_random(input int count);
        repeat (count) drive_command(random_command());
    endtask

    // Waits until every expected word has come back and the block is idle.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (tracker.pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Receiver: random stall bursts, plus one long hold-off on request so
    // that the result register stays full and the input backs up.
    initial begin
        forever begin
            @(posedge clk);
            if (hold_off_request) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(posedge clk);
                hold_off_request = 1'b0;
            end
            else if (idling && $urandom_range(0, 5) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(0, 16)) @(posedge clk);
            end
            else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    always @(posedge clk) begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            tracker.check_result(m_axis_tdata);
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("simulation failed");
        $finish;
    end

    initial begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Small limits first, so that full lists show up in the directed part.
        set_limits(1, 32, 0, 32);
        drive_command(command(KIND_ADD, TYPE_PC, 16'h0000, 0, 0, 0, 0));
        drive_command(command(KIND_ADD, TYPE_PC, 16'h0001, 0, 0, 0, 0));
        drive_command(command(KIND_ADD, TYPE_NPC, 16'h0002, 1, 10, 0, 0));
        drive_command(command(KIND_ADD, TYPE_OBJECT, 16'hFFFF, 1, 255, 0, 0));
        drive_command(command(KIND_ADD, TYPE_MONSTER, 16'h0003, 0, -1, 0, 0));
        drive_command(command(KIND_REMOVE, TYPE_OBJECT, 16'hFFFF, 1, 255, 0, 0));
        drive_command(command(KIND_REMOVE, TYPE_OBJECT, 16'hFFFF, 1, 255, 0, 0));
        drive_command(command(KIND_REMOVE, TYPE_MONSTER, 16'h0003, 0, -2, 0, 0));
        // One entity walks from a small negative position across the grid
        // and off its edge.
        drive_command(command(KIND_MOVE, TYPE_MONSTER, 7, 0, -1, -1, -1023));
        drive_command(command(KIND_MOVE, TYPE_MONSTER, 7, 0, 0, 1023, 0));
        drive_command(command(KIND_MOVE, TYPE_MONSTER, 7, 0, 0, 16383, 16383));
        drive_command(command(KIND_MOVE, TYPE_MONSTER, 7, 0, 255, 16384, 0));
        drive_command(command(KIND_MOVE, TYPE_MONSTER, 7, 0, -1, -1024, 5));
        drive_command(command(KIND_MOVE, TYPE_MONSTER, 7, 0, -256, 8388607, 8388607));
        drive_command(command(KIND_MOVE, TYPE_MONSTER, 7, 0, -200, -8388608, -8388608));
        // The previous zone does not hold this entity; the move still lands.
        drive_command(command(KIND_MOVE, TYPE_MONSTER, 8, 0, 5, 1024, 1025));
        drive_command(command(KIND_MOVE, TYPE_PC, 9, 0, -1, 0, 0));
        drive_command(command(KIND_ADD, TYPE_MONSTER, 8, 0, 17, 0, 0));
        drive_command(command(KIND_REMOVE, TYPE_MONSTER, 8, 0, 17, 0, 0));
        drive_command(command(KIND_REMOVE, TYPE_MONSTER, 8, 0, 17, 0, 0));
        drive_command(command(KIND_NONE, TYPE_MONSTER, 8, 0, 17, 0, 0));
        drive_command(command(KIND_ADD, TYPE_PC, 4, 2, 3, 0, 0));
        drive_command(command(KIND_MOVE, TYPE_NPC, 4, 3, 3, 0, 0));
        drive_command(command(KIND_NONE, TYPE_OBJECT, 4, 3, 3, 0, 0));
        settle();

        set_limits(0, 5, 32, 2);
        start_phase(4, 30, 25);
        hold_off_request = 1'b1;
        run_random(200);
        settle();

        // One busy list in this phase, filled past the largest limit.
        set_limits(32, 32, 32, 32);
        start_phase(1, 60, 10);
        run_random(170);
        settle();

        set_limits(3, 0, 17, 32);
        start_phase(2, 35, 20);
        run_random(180);
        settle();

        idling = 1'b0;
        set_limits(int'($urandom_range(0, 32)), int'($urandom_range(0, 32)),
                   int'($urandom_range(0, 32)), int'($urandom_range(0, 32)));
        start_phase(3, 30, 25);
        run_random(180);
        settle();

        if (tracker.mismatches == 0 && tracker.pending_results.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

[grid_zone_membership_table.f]
+incdir+hw/rtl
hw/rtl/gzmt_pkg.sv
hw/rtl/gzmt_ram.sv
hw/rtl/gzmt_zone.sv
hw/rtl/gzmt_seq.sv
hw/rtl/grid_zone_membership_table.sv
verif/tb.sv
